// ===== sv/brcu_pkg.sv =====
// Shared widths, codes and beat types of the breakpoint and run-control unit.
package brcu_pkg;

    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 8;
    localparam int SRC_W      = 3;
    localparam int MODE_W     = 2;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 2;
    localparam int CNT_W      = 32;
    localparam int TGT_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 38;
    localparam int MAX_BP     = 4;
    localparam int NUM_BP_DEF = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Event sources.
    localparam logic [SRC_W-1:0] SRC_CPU = 3'd0;
    localparam logic [SRC_W-1:0] SRC_SMP = 3'd1;
    localparam logic [SRC_W-1:0] SRC_APU = 3'd4;

    // Breakpoint modes.
    localparam logic [MODE_W-1:0] MODE_DIS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd3;

    // Event kinds on the input stream.
    localparam logic [ACT_W-1:0] ACT_EXEC  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_BAD   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BP0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_FOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_TO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TO  = 3'd7;

    // Event travelling down the cell chain, with the match results so far.
    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [SRC_W-1:0]  src;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
        logic              ahit;
        logic [IDX_W-1:0]  aidx;
    } t_tok;

    // Result beat; halt sits in bit 0.
    typedef struct packed {
        logic [IDX_W-1:0] alias_index;
        logic             alias_hit;
        logic [CNT_W-1:0] bp_count;
        logic [IDX_W-1:0] bp_index;
        logic             bp_hit;
        logic             trace;
        logic             halt;
    } t_res;

endpackage

// ===== sv/brcu_cell.sv =====
// One breakpoint cell: holds an entry and its hit counter, tests the passing event.
module brcu_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_hold,
    input  logic                      i_cfg_we,
    input  logic [brcu_pkg::CFG_W-1:0] i_cfg_data,
    input  brcu_pkg::t_tok            i_tok,
    output brcu_pkg::t_tok            o_tok
);

    logic [brcu_pkg::CFG_W-1:0]  r_entry;
    logic [brcu_pkg::CNT_W-1:0]  r_cnt;
    logic [brcu_pkg::CNT_W-1:0]  n_cnt;
    logic [brcu_pkg::CNT_W-1:0]  cnt_inc;
    brcu_pkg::t_tok              r_tok;
    brcu_pkg::t_tok              n_tok;

    logic [brcu_pkg::ADDR_W-1:0] e_addr;
    logic [brcu_pkg::DATA_W-1:0] e_data;
    logic                        e_den;
    logic [brcu_pkg::MODE_W-1:0] e_mode;
    logic [brcu_pkg::SRC_W-1:0]  e_src;
    logic                        base_match;

    assign e_addr = r_entry[23:0];
    assign e_data = r_entry[31:24];
    assign e_den  = r_entry[32];
    assign e_mode = r_entry[34:33];
    assign e_src  = r_entry[37:35];

    assign cnt_inc = (r_cnt == {brcu_pkg::CNT_W{1'b1}}) ? r_cnt : r_cnt + brcu_pkg::CNT_W'(1);

    // Everything but the source; the data byte only counts for read and write entries.
    assign base_match = (e_mode != brcu_pkg::MODE_DIS) && (e_mode == i_tok.mode) &&
                        (e_addr == i_tok.addr) &&
                        ((e_mode == brcu_pkg::MODE_EXEC) || !e_den || (e_data == i_tok.data));

    always_comb begin
        n_tok = i_tok;
        n_cnt = r_cnt;
        if (i_tok.valid && base_match) begin
            priority if (!i_tok.hit && (e_src == i_tok.src)) begin
                n_tok.hit   = 1'b1;
                n_tok.idx   = brcu_pkg::IDX_W'(IDX);
                n_tok.count = cnt_inc;
                n_cnt       = cnt_inc;
            end else if (!i_tok.ahit && (e_src == brcu_pkg::SRC_APU) &&
                         (i_tok.src == brcu_pkg::SRC_SMP) &&
                         (i_tok.mode != brcu_pkg::MODE_EXEC)) begin
                // An smp read or write is also checked against the apu entries.
                n_tok.ahit = 1'b1;
                n_tok.aidx = brcu_pkg::IDX_W'(IDX);
                n_cnt      = cnt_inc;
            end else begin
                // Other entries and already claimed matches leave the event as is.
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_cnt       <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry <= i_cfg_data;
            end
            if (!i_hold) begin
                r_tok <= n_tok;
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/brcu_ctrl.sv =====
// Run-control stage: run-for, run-to, step-for, step-to and the result register.
module brcu_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brcu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brcu_pkg::CFG_W-1:0]     i_cfg_data,
    input  brcu_pkg::t_tok                i_tok,
    input  logic                          i_m_tready,
    output logic                          o_take,
    output logic                          o_valid,
    output brcu_pkg::t_res                o_res
);

    logic [brcu_pkg::CNT_W-1:0]  r_rf, n_rf;
    logic [brcu_pkg::CNT_W-1:0]  r_sf, n_sf;
    logic                        r_rt_arm, n_rt_arm;
    logic                        r_st_arm, n_st_arm;
    logic [brcu_pkg::ADDR_W-1:0] r_rt_addr;
    logic [brcu_pkg::ADDR_W-1:0] r_st_addr;
    logic                        r_valid;
    brcu_pkg::t_res              r_res;
    brcu_pkg::t_res              n_res;
    logic                        halt;
    logic                        trace;
    logic                        cpu_exec;

    assign o_take   = i_tok.valid && (!r_valid || i_m_tready);
    assign cpu_exec = (i_tok.src == brcu_pkg::SRC_CPU) && (i_tok.mode == brcu_pkg::MODE_EXEC);

    always_comb begin
        halt     = i_tok.hit || i_tok.ahit;
        trace    = 1'b0;
        n_rf     = r_rf;
        n_sf     = r_sf;
        n_rt_arm = r_rt_arm;
        n_st_arm = r_st_arm;
        // The checks run in order; the first halt ends the sequence.
        if (!halt && cpu_exec) begin
            if (r_rf != '0) begin
                n_rf = r_rf - brcu_pkg::CNT_W'(1);
                halt = (r_rf == brcu_pkg::CNT_W'(1));
            end
            if (!halt && r_rt_arm && (i_tok.addr == r_rt_addr)) begin
                halt = 1'b1;
            end
            if (!halt && (r_sf != '0)) begin
                trace = 1'b1;
                n_sf  = r_sf - brcu_pkg::CNT_W'(1);
                halt  = (r_sf == brcu_pkg::CNT_W'(1));
            end
            if (!halt && r_st_arm) begin
                trace = 1'b1;
                halt  = (i_tok.addr == r_st_addr);
            end
        end
        if (halt) begin
            n_rf     = '0;
            n_sf     = '0;
            n_rt_arm = 1'b0;
            n_st_arm = 1'b0;
        end
        n_res.halt        = halt;
        n_res.trace       = trace;
        n_res.bp_hit      = i_tok.hit;
        n_res.bp_index    = i_tok.hit ? i_tok.idx : '0;
        n_res.bp_count    = i_tok.hit ? i_tok.count : '0;
        n_res.alias_hit   = i_tok.ahit;
        n_res.alias_index = i_tok.ahit ? i_tok.aidx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf      <= '0;
            r_sf      <= '0;
            r_rt_arm  <= 1'b0;
            r_st_arm  <= 1'b0;
            r_rt_addr <= '0;
            r_st_addr <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    brcu_pkg::REG_RUN_FOR: begin
                        r_rf <= i_cfg_data[brcu_pkg::CNT_W-1:0];
                    end
                    brcu_pkg::REG_RUN_TO: begin
                        r_rt_addr <= i_cfg_data[brcu_pkg::ADDR_W-1:0];
                        r_rt_arm  <= i_cfg_data[brcu_pkg::TGT_W-1];
                    end
                    brcu_pkg::REG_STEP_FOR: begin
                        r_sf <= i_cfg_data[brcu_pkg::CNT_W-1:0];
                    end
                    brcu_pkg::REG_STEP_TO: begin
                        r_st_addr <= i_cfg_data[brcu_pkg::ADDR_W-1:0];
                        r_st_arm  <= i_cfg_data[brcu_pkg::TGT_W-1];
                    end
                    default: begin
                        // Breakpoint entries live in the cells.
                    end
                endcase
            end else if (o_take) begin
                r_rf     <= n_rf;
                r_sf     <= n_sf;
                r_rt_arm <= n_rt_arm;
                r_st_arm <= n_st_arm;
            end
            if (o_take) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/breakpoint_run_control_unit.sv =====
// Breakpoint and run-control unit for a debug monitor.
//
// Usage: each beat on the s_axis channel is one bus event. s_axis_tuser carries
// the event kind (execute, read, write); s_axis_tdata carries source, address and
// data byte. The event walks a chain of NUM_BREAKPOINTS cells, one cell per cycle;
// each cell holds one breakpoint entry and its hit counter, and the lowest matching
// cell claims the hit. A final stage applies the run-for, run-to, step-for and
// step-to controls and loads the result register that drives m_axis.
// A new event is taken only once the last one has left the chain for the result
// register; s_axis_tready is low while an event is in the chain.
// A finished result waits in the output register while the next event is taken;
// if the receiver still stalls when that next event reaches the chain's end, the
// chain holds it until the output register frees.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
// edge and must be made while the unit is idle; the unit does not enforce this.
// Reset (synchronous, active low) clears all entries, hit counters and run
// controls and empties the chain and the output register.
module breakpoint_run_control_unit #(
    parameter int NUM_BREAKPOINTS = brcu_pkg::NUM_BP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // bits: source[2:0], addr[26:3], data[34:27], zero fill[39:35]
    input  logic [brcu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // bits: action[1:0]
    input  logic [brcu_pkg::ACT_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bits: halt[0], trace[1], bp_hit[2], bp_index[4:3], bp_count[36:5],
    //       alias_hit[37], alias_index[39:38]
    output logic [brcu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [brcu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [brcu_pkg::CFG_W-1:0]        i_cfg_data
);

    brcu_pkg::t_tok              tok [0:NUM_BREAKPOINTS];
    brcu_pkg::t_res              res;
    logic [brcu_pkg::MODE_W-1:0] in_mode;
    logic                        accept;
    logic                        take;
    logic                        hold;
    logic                        r_busy;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_busy;
    assign hold          = tok[NUM_BREAKPOINTS].valid && !take;

    always_comb begin
        unique case (s_axis_tuser)
            brcu_pkg::ACT_EXEC:  in_mode = brcu_pkg::MODE_EXEC;
            brcu_pkg::ACT_READ:  in_mode = brcu_pkg::MODE_READ;
            brcu_pkg::ACT_WRITE: in_mode = brcu_pkg::MODE_WRITE;
            // The invalid kind matches nothing and changes no hit counter or run control.
            default:             in_mode = brcu_pkg::MODE_DIS;
        endcase
    end

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = accept;
        tok[0].mode  = in_mode;
        tok[0].src   = s_axis_tdata[2:0];
        tok[0].addr  = s_axis_tdata[26:3];
        tok[0].data  = s_axis_tdata[34:27];
    end

    for (genvar g = 0; g < NUM_BREAKPOINTS; g++) begin : g_cell
        logic cell_we;
        assign cell_we = i_cfg_we &&
                         (i_cfg_index == brcu_pkg::CFG_IDX_W'(brcu_pkg::REG_BP0 + g));
        brcu_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_hold     (hold),
            .i_cfg_we   (cell_we),
            .i_cfg_data (i_cfg_data),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1])
        );
    end

    brcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tok       (tok[NUM_BREAKPOINTS]),
        .i_m_tready  (m_axis_tready),
        .o_take      (take),
        .o_valid     (m_axis_tvalid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (take) begin
            r_busy <= 1'b0;
        end
    end

    assign m_axis_tdata = res;

endmodule

// ===== sv/brcu_chk.sv =====
// Port-level checks for the breakpoint and run-control unit, bound to the top level.
module brcu_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [brcu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // Only one event is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an event was in flight");

    a_zero_when_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |->
            (m_axis_tdata[4:3] == 2'd0) && (m_axis_tdata[36:5] == 32'd0))
        else $error("breakpoint index or count set without a hit");

    // A breakpoint or alias hit always halts, with a nonzero count for a hit.
    a_hit_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2] || m_axis_tdata[37])) |->
            m_axis_tdata[0] && (!m_axis_tdata[2] || (m_axis_tdata[36:5] != 32'd0)))
        else $error("hit without halt or with zero count");

    // Tracing only happens when no breakpoint stopped the event.
    a_trace_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (!m_axis_tdata[2] && !m_axis_tdata[37]))
        else $error("trace set together with a breakpoint hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind breakpoint_run_control_unit brcu_chk u_brcu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
